// ===== sv/uv_sphere_tessellator_assert.svh =====
// ----------------------------------------------------------------------------
// uv_sphere_tessellator assertion macros
// Shared concurrent assertion forms for the sphere tessellator checkers.
// ----------------------------------------------------------------------------
`ifndef UV_SPHERE_TESSELLATOR_ASSERT_SVH
`define UV_SPHERE_TESSELLATOR_ASSERT_SVH

// Implication checked while out of reset.
`define UVS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("uvs assertion failed");

// Next-cycle implication checked while out of reset.
`define UVS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("uvs assertion failed");

`endif

// ===== sv/uvs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// uvs_pkg
// Types, constants and fixed-point helpers of the UV sphere tessellator.
// ----------------------------------------------------------------------------
package uvs_pkg;

  localparam int SineTableDepthDef = 1024;
  localparam int ColourCountDef    = 4;
  localparam int QueueDepth        = 2;
  localparam int TrigCount         = 8;
  localparam int StepCount         = 14;
  localparam int VertexLast        = 5;

  localparam logic [15:0] PHASE_QUARTER = 16'd16384;
  localparam logic [15:0] PHASE_SOUTH   = 16'd49152;
  localparam logic [10:0] COUNT_MAX     = 11'd1024;

  // configuration register indexes
  localparam logic [2:0] REG_RADIUS    = 3'd0;
  localparam logic [2:0] REG_MER_COUNT = 3'd1;
  localparam logic [2:0] REG_PAR_COUNT = 3'd2;
  localparam logic [2:0] REG_MER_STEP  = 3'd3;
  localparam logic [2:0] REG_PAR_STEP  = 3'd4;

  // trig slots
  localparam logic [2:0] TRIG_CM0 = 3'd0;
  localparam logic [2:0] TRIG_SM0 = 3'd1;
  localparam logic [2:0] TRIG_CM1 = 3'd2;
  localparam logic [2:0] TRIG_SM1 = 3'd3;
  localparam logic [2:0] TRIG_CP0 = 3'd4;
  localparam logic [2:0] TRIG_SP0 = 3'd5;
  localparam logic [2:0] TRIG_CP1 = 3'd6;
  localparam logic [2:0] TRIG_SP1 = 3'd7;

  // multiply steps
  localparam logic [3:0] STEP_RC0 = 4'd0;
  localparam logic [3:0] STEP_RC1 = 4'd1;
  localparam logic [3:0] STEP_YB  = 4'd2;
  localparam logic [3:0] STEP_YT  = 4'd3;
  localparam logic [3:0] STEP_U1  = 4'd4;
  localparam logic [3:0] STEP_U2  = 4'd5;
  localparam logic [3:0] STEP_X1  = 4'd6;
  localparam logic [3:0] STEP_Z1  = 4'd7;
  localparam logic [3:0] STEP_X2  = 4'd8;
  localparam logic [3:0] STEP_Z2  = 4'd9;
  localparam logic [3:0] STEP_X1A = 4'd10;
  localparam logic [3:0] STEP_Z1A = 4'd11;
  localparam logic [3:0] STEP_X2A = 4'd12;
  localparam logic [3:0] STEP_Z2A = 4'd13;

  typedef logic [15:0] phase_t;

  typedef struct packed {
    phase_t     mer0;
    phase_t     mer1;
    phase_t     par0;
    phase_t     par1;
    logic [1:0] colour;
    logic       done;
  } quad_desc_t;

  typedef struct packed {
    logic [14:0] radius;
    logic [10:0] mer_count;
    logic [10:0] par_count;
    phase_t      mer_step;
    phase_t      par_step;
  } uvs_cfg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_MUL,
    BK_EMIT
  } back_state_t;

  function automatic logic [10:0] eff_count(input logic [10:0] c);
    if (c == 11'd0) return 11'd1;
    if (c > COUNT_MAX) return COUNT_MAX;
    return c;
  endfunction

  // round half away from zero by s bits, then saturate to signed 16
  function automatic logic signed [15:0] round_sat(input logic signed [49:0] p,
                                                   input logic [4:0] s);
    logic        neg;
    logic [49:0] mag;
    logic [49:0] half;
    neg  = p[49];
    mag  = neg ? 50'(-p) : 50'(p);
    half = 50'd1 << (s - 5'd1);
    mag  = (mag + half) >> s;
    if (!neg) return (mag > 50'd32767) ? 16'sh7FFF : 16'(mag);
    return (mag > 50'd32768) ? 16'sh8000 : 16'(~mag + 50'd1);
  endfunction

  function automatic logic [15:0] u_cap(input logic signed [49:0] p);
    logic signed [50:0] t;
    t = 51'(p) + 51'sd1073758208;
    t = t >>> 15;
    if (t < 0) return 16'd0;
    if (t > 51'sd65535) return 16'hFFFF;
    return 16'(t);
  endfunction

  function automatic logic [15:0] v_cap(input logic signed [16:0] sp);
    logic signed [18:0] t;
    t = 19'sd32768 - 19'(sp);
    if (t > 19'sd65535) return 16'hFFFF;
    return 16'(t);
  endfunction

endpackage
`default_nettype wire

// ===== sv/uvs_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// uvs_front
// Walk sequencer: accepts ticks, tracks the quad walk and queues descriptors.
// ----------------------------------------------------------------------------
module uvs_front
  import uvs_pkg::*;
#(
  parameter int COLOUR_COUNT = ColourCountDef
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_restart,
  input  wire uvs_cfg_t   cfg,
  input  wire logic       q_full,
  output logic            q_push,
  output quad_desc_t      q_desc
);

  localparam int CW = (COLOUR_COUNT > 1) ? $clog2(COLOUR_COUNT) : 1;

  logic [9:0]    mc_r, mc_nxt, pc_r, pc_nxt;
  phase_t        mp_r, mp_nxt, pp_r, pp_nxt;
  logic [CW-1:0] cc_r, cc_nxt;
  logic          fin_r, fin_nxt;

  logic [9:0]    e_mc, e_pc;
  phase_t        e_mp, e_pp;
  logic [CW-1:0] e_cc;
  logic          e_fin;
  logic [CW+1:0] cc_ext;
  logic          accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign cc_ext   = {2'b00, e_cc};

  always_comb begin
    e_mc  = in_restart ? 10'd0 : mc_r;
    e_pc  = in_restart ? 10'd0 : pc_r;
    e_mp  = in_restart ? 16'd0 : mp_r;
    e_pp  = in_restart ? PHASE_SOUTH : pp_r;
    e_cc  = in_restart ? '0 : cc_r;
    e_fin = in_restart ? 1'b0 : fin_r;

    mc_nxt  = mc_r;
    pc_nxt  = pc_r;
    mp_nxt  = mp_r;
    pp_nxt  = pp_r;
    cc_nxt  = cc_r;
    fin_nxt = fin_r;
    q_push  = 1'b0;

    q_desc.mer0   = e_mp;
    q_desc.mer1   = e_mp + cfg.mer_step;
    q_desc.par0   = e_pp;
    q_desc.par1   = e_pp + cfg.par_step;
    q_desc.colour = cc_ext[1:0];
    q_desc.done   = 1'b0;

    if (accept) begin
      mc_nxt  = e_mc;
      pc_nxt  = e_pc;
      mp_nxt  = e_mp;
      pp_nxt  = e_pp;
      cc_nxt  = e_cc;
      fin_nxt = e_fin;
      if (!e_fin) begin
        q_push = 1'b1;
        cc_nxt = (e_cc == CW'(COLOUR_COUNT - 1)) ? '0 : e_cc + 1'b1;
        mc_nxt = e_mc + 10'd1;
        mp_nxt = e_mp + cfg.mer_step;
        if ({1'b0, e_mc} + 11'd1 >= eff_count(cfg.mer_count)) begin
          mc_nxt = 10'd0;
          mp_nxt = 16'd0;
          pc_nxt = e_pc + 10'd1;
          pp_nxt = e_pp + cfg.par_step;
          if ({1'b0, e_pc} + 11'd1 >= eff_count(cfg.par_count)) begin
            pc_nxt  = 10'd0;
            fin_nxt = 1'b1;
          end
        end
        q_desc.done = fin_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mc_r  <= 10'd0;
      pc_r  <= 10'd0;
      mp_r  <= 16'd0;
      pp_r  <= PHASE_SOUTH;
      cc_r  <= '0;
      fin_r <= 1'b0;
    end else begin
      mc_r  <= mc_nxt;
      pc_r  <= pc_nxt;
      mp_r  <= mp_nxt;
      pp_r  <= pp_nxt;
      cc_r  <= cc_nxt;
      fin_r <= fin_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/uvs_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// uvs_queue
// Short descriptor queue between the walk sequencer and the vertex engine.
// ----------------------------------------------------------------------------
module uvs_queue
  import uvs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire quad_desc_t  push_desc,
  input  wire logic        pop,
  output logic             head_valid,
  output quad_desc_t       head_desc,
  output logic             full
);

  localparam int PW = $clog2(QueueDepth);

  quad_desc_t              mem_r [QueueDepth];
  logic [PW-1:0]           wr_r, wr_nxt, rd_r, rd_nxt;
  logic [$clog2(QueueDepth+1)-1:0] cnt_r, cnt_nxt;

  assign head_valid = (cnt_r != '0);
  assign full       = (cnt_r == ($clog2(QueueDepth+1))'(QueueDepth));
  assign head_desc  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = push ? PW'(wr_r + 1'b1) : wr_r;
    rd_nxt  = pop ? PW'(rd_r + 1'b1) : rd_r;
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_desc;
  end

endmodule
`default_nettype wire

// ===== sv/uvs_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// uvs_back
// Vertex engine: sine lookups, shared multiplier and six-vertex emission.
// ----------------------------------------------------------------------------
module uvs_back
  import uvs_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = SineTableDepthDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [14:0] radius,
  input  wire logic        q_valid,
  input  wire quad_desc_t  q_desc,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [15:0] out_pos_x,
  output logic signed [15:0] out_pos_y,
  output logic signed [15:0] out_pos_z,
  output logic [15:0]      out_tex_u,
  output logic [15:0]      out_tex_v,
  output logic [1:0]       out_colour_index,
  output logic             out_last_of_quad,
  output logic             out_mesh_done
);

  localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int IW = 14 + AW;

  // Taylor series term divisors (2k)(2k+1)
  localparam longint unsigned TermDiv [1:8] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
  };

  typedef logic [15:0] rom_arr_t [SINE_TABLE_DEPTH + 1];

  function automatic rom_arr_t build_rom();
    rom_arr_t          rom;
    longint unsigned   x, x2, term, r;
    longint            sum;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      x    = (64'd1686629713 * longint'(i)) / SINE_TABLE_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= 8; k++) begin
        term = ((term * x2) >> 30) / TermDiv[k];
        if (k[0]) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      r = (longint'(sum) * 32768 + (64'd1 << 29)) >> 30;
      if (r > 32768) r = 32768;
      rom[i] = 16'(r);
    end
    return rom;
  endfunction

  localparam rom_arr_t SineRom = build_rom();

  back_state_t state_r, state_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        emit;

  quad_desc_t  desc_r;
  logic [15:0] rom_q_r;
  logic        neg_q_r;
  logic signed [16:0] trig_r [TrigCount];
  logic signed [49:0] prod_r;
  logic signed [32:0] rc0_r, rc1_r;
  logic signed [15:0] x1_r, z1_r, x2_r, z2_r, x1a_r, z1a_r, x2a_r, z2a_r;
  logic signed [15:0] yb_r, yt_r;
  logic [15:0]        u1_r, u2_r;

  phase_t             fphase;
  logic [IW-1:0]      fscaled;
  logic [AW-1:0]      fidx, faddr;
  logic signed [32:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [32:0] r_ext;
  logic [3:0]         wstep;

  assign r_ext = {18'd0, radius};
  assign wstep = cnt_r - 4'd1;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    q_pop     = 1'b0;
    emit      = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = BK_FETCH;
          cnt_nxt   = 4'd0;
        end
      end
      BK_FETCH: begin
        if (cnt_r == 4'(TrigCount)) begin
          state_nxt = BK_MUL;
          cnt_nxt   = 4'd0;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      BK_MUL: begin
        if (cnt_r == 4'(StepCount)) begin
          state_nxt = BK_EMIT;
          cnt_nxt   = 4'd0;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      BK_EMIT: begin
        if (!out_valid || out_ready) begin
          emit = 1'b1;
          if (cnt_r == 4'(VertexLast)) begin
            state_nxt = BK_IDLE;
            cnt_nxt   = 4'd0;
          end else begin
            cnt_nxt = cnt_r + 4'd1;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
        cnt_nxt   = 4'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      cnt_r     <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // phase and ROM address for the current fetch slot
  always_comb begin
    case (cnt_r[2:0])
      TRIG_CM0: fphase = desc_r.mer0 + PHASE_QUARTER;
      TRIG_SM0: fphase = desc_r.mer0;
      TRIG_CM1: fphase = desc_r.mer1 + PHASE_QUARTER;
      TRIG_SM1: fphase = desc_r.mer1;
      TRIG_CP0: fphase = desc_r.par0 + PHASE_QUARTER;
      TRIG_SP0: fphase = desc_r.par0;
      TRIG_CP1: fphase = desc_r.par1 + PHASE_QUARTER;
      TRIG_SP1: fphase = desc_r.par1;
      default:  fphase = desc_r.mer0;
    endcase
    fscaled = IW'(fphase[13:0]) * IW'(SINE_TABLE_DEPTH);
    fidx    = AW'(fscaled >> 14);
    faddr   = fphase[14] ? AW'(SINE_TABLE_DEPTH) - fidx : fidx;
  end

  // multiplier operand select
  always_comb begin
    case (cnt_r)
      STEP_RC0: begin mul_a = r_ext;  mul_b = trig_r[TRIG_CP0]; end
      STEP_RC1: begin mul_a = r_ext;  mul_b = trig_r[TRIG_CP1]; end
      STEP_YB:  begin mul_a = r_ext;  mul_b = trig_r[TRIG_SP0]; end
      STEP_YT:  begin mul_a = r_ext;  mul_b = trig_r[TRIG_SP1]; end
      STEP_U1:  begin mul_a = 33'(trig_r[TRIG_CP0]); mul_b = trig_r[TRIG_SM0]; end
      STEP_U2:  begin mul_a = 33'(trig_r[TRIG_CP0]); mul_b = trig_r[TRIG_SM1]; end
      STEP_X1:  begin mul_a = rc0_r;  mul_b = trig_r[TRIG_CM0]; end
      STEP_Z1:  begin mul_a = rc0_r;  mul_b = trig_r[TRIG_SM0]; end
      STEP_X2:  begin mul_a = rc0_r;  mul_b = trig_r[TRIG_CM1]; end
      STEP_Z2:  begin mul_a = rc0_r;  mul_b = trig_r[TRIG_SM1]; end
      STEP_X1A: begin mul_a = rc1_r;  mul_b = trig_r[TRIG_CM0]; end
      STEP_Z1A: begin mul_a = rc1_r;  mul_b = trig_r[TRIG_SM0]; end
      STEP_X2A: begin mul_a = rc1_r;  mul_b = trig_r[TRIG_CM1]; end
      STEP_Z2A: begin mul_a = rc1_r;  mul_b = trig_r[TRIG_SM1]; end
      default:  begin mul_a = r_ext;  mul_b = trig_r[TRIG_CP0]; end
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state_r == BK_IDLE && q_valid) desc_r <= q_desc;
    if (state_r == BK_FETCH) begin
      rom_q_r <= SineRom[faddr];
      neg_q_r <= fphase[15];
      if (cnt_r != 4'd0) begin
        trig_r[wstep[2:0]] <= neg_q_r ? -$signed({1'b0, rom_q_r})
                                      : $signed({1'b0, rom_q_r});
      end
    end
    if (state_r == BK_MUL) begin
      prod_r <= 50'(mul_a) * 50'(mul_b);
      if (cnt_r != 4'd0) begin
        case (wstep)
          STEP_RC0: rc0_r <= prod_r[32:0];
          STEP_RC1: rc1_r <= prod_r[32:0];
          STEP_YB:  yb_r  <= round_sat(prod_r, 5'd15);
          STEP_YT:  yt_r  <= round_sat(prod_r, 5'd15);
          STEP_U1:  u1_r  <= u_cap(prod_r);
          STEP_U2:  u2_r  <= u_cap(prod_r);
          STEP_X1:  x1_r  <= round_sat(prod_r, 5'd30);
          STEP_Z1:  z1_r  <= round_sat(prod_r, 5'd30);
          STEP_X2:  x2_r  <= round_sat(prod_r, 5'd30);
          STEP_Z2:  z2_r  <= round_sat(prod_r, 5'd30);
          STEP_X1A: x1a_r <= round_sat(prod_r, 5'd30);
          STEP_Z1A: z1a_r <= round_sat(prod_r, 5'd30);
          STEP_X2A: x2a_r <= round_sat(prod_r, 5'd30);
          STEP_Z2A: z2a_r <= round_sat(prod_r, 5'd30);
          default:  ;
        endcase
      end
    end
    if (emit) begin
      out_colour_index <= desc_r.colour;
      out_last_of_quad <= (cnt_r == 4'(VertexLast));
      out_mesh_done    <= (cnt_r == 4'(VertexLast)) && desc_r.done;
      case (cnt_r)
        4'd0, 4'd3: begin
          out_pos_x <= x1_r;  out_pos_y <= yb_r; out_pos_z <= z1_r;
          out_tex_u <= u1_r;  out_tex_v <= v_cap(trig_r[TRIG_SP0]);
        end
        4'd1: begin
          out_pos_x <= x1a_r; out_pos_y <= yt_r; out_pos_z <= z1a_r;
          out_tex_u <= u1_r;  out_tex_v <= v_cap(trig_r[TRIG_SP1]);
        end
        4'd2, 4'd4: begin
          out_pos_x <= x2a_r; out_pos_y <= yt_r; out_pos_z <= z2a_r;
          out_tex_u <= u2_r;  out_tex_v <= v_cap(trig_r[TRIG_SP1]);
        end
        default: begin
          out_pos_x <= x2_r;  out_pos_y <= yb_r; out_pos_z <= z2_r;
          out_tex_u <= u2_r;  out_tex_v <= v_cap(trig_r[TRIG_SP0]);
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/uv_sphere_tessellator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// uv_sphere_tessellator
// Latitude-longitude sphere mesh generator, one quad (six vertices) per tick.
// ----------------------------------------------------------------------------
// Each accepted tick produces one quad as six output words (left-bottom,
// left-top, right-top, left-bottom, right-top, right-bottom); a tick with
// restart set first rewinds the walk to the south pole, and ticks after the
// final quad produce nothing. In the vertex engine a quad is taken from
// the queue, then goes through sine/cosine lookups in the single-port
// quarter-wave ROM, then through the one shared 33x17 multiplier (14
// products), and then its vertices are handed out, which output stalls can
// hold. The front sequencer and a two-entry descriptor queue keep taking
// ticks while the engine works, until the queue is full.
// Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module uv_sphere_tessellator
  import uvs_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = SineTableDepthDef,
  parameter int COLOUR_COUNT     = ColourCountDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_restart,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [15:0] out_pos_x,
  output logic signed [15:0] out_pos_y,
  output logic signed [15:0] out_pos_z,
  output logic [15:0]      out_tex_u,
  output logic [15:0]      out_tex_v,
  output logic [1:0]       out_colour_index,
  output logic             out_last_of_quad,
  output logic             out_mesh_done
);

  uvs_cfg_t   cfg_r;
  logic       q_push, q_pop, q_full, q_valid;
  quad_desc_t push_desc, head_desc;

  // configuration registers; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.radius    <= 15'd256;
      cfg_r.mer_count <= 11'd16;
      cfg_r.par_count <= 11'd8;
      cfg_r.mer_step  <= 16'd4096;
      cfg_r.par_step  <= 16'd4096;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_RADIUS:    cfg_r.radius    <= cfg_wdata[14:0];
        REG_MER_COUNT: cfg_r.mer_count <= cfg_wdata[10:0];
        REG_PAR_COUNT: cfg_r.par_count <= cfg_wdata[10:0];
        REG_MER_STEP:  cfg_r.mer_step  <= cfg_wdata;
        REG_PAR_STEP:  cfg_r.par_step  <= cfg_wdata;
        default:       ;
      endcase
    end
  end

  // front: walk state, one descriptor per non-finished tick
  uvs_front #(
    .COLOUR_COUNT(COLOUR_COUNT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_restart(in_restart),
    .cfg       (cfg_r),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_desc    (push_desc)
  );

  // hold quad descriptors between front and engine
  uvs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (push_desc),
    .pop       (q_pop),
    .head_valid(q_valid),
    .head_desc (head_desc),
    .full      (q_full)
  );

  // back: trig lookups, products and vertex output register
  uvs_back #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .radius          (cfg_r.radius),
    .q_valid         (q_valid),
    .q_desc          (head_desc),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y),
    .out_pos_z       (out_pos_z),
    .out_tex_u       (out_tex_u),
    .out_tex_v       (out_tex_v),
    .out_colour_index(out_colour_index),
    .out_last_of_quad(out_last_of_quad),
    .out_mesh_done   (out_mesh_done)
  );

endmodule
`default_nettype wire

// ===== sv/uvs_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// uvs_checker
// Port-level checks of the sphere tessellator, bound to the top level.
// ----------------------------------------------------------------------------
`include "uv_sphere_tessellator_assert.svh"

module uvs_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_last_of_quad,
  input wire logic out_mesh_done
);

  // mesh end only ever falls on a quad's closing vertex
  `UVS_ASSERT_IMP(a_done_on_last, clk, rst_n, out_valid && out_mesh_done, out_last_of_quad)

  // a stalled word stays offered
  `UVS_ASSERT_NXT(a_hold_valid, clk, rst_n, out_valid && !out_ready, out_valid)

  // nothing is offered right out of reset
  `UVS_ASSERT_IMP(a_reset_quiet, clk, rst_n, $rose(rst_n), !out_valid)

endmodule

bind uv_sphere_tessellator uvs_checker u_uvs_checker (.*);
`default_nettype wire
